>>> src/u8u16_pkg.sv
`timescale 1ns / 1ps

package u8u16_pkg;

    localparam int BYTE_W = 8;
    localparam int UNIT_W = 16;
    localparam int STAT_W = 3;

    // Sequence phase, one-hot
    typedef enum logic [4:0] {
        PH_IDLE   = 5'b00001,
        PH_TWO    = 5'b00010,
        PH_THREE1 = 5'b00100,
        PH_THREE2 = 5'b01000,
        PH_DROP   = 5'b10000
    } t_phase;

    typedef enum logic [STAT_W-1:0] {
        ST_UNIT     = 3'd0,
        ST_END      = 3'd1,
        ST_STRAY    = 3'd2,
        ST_MISSING  = 3'd3,
        ST_OVERLONG = 3'd4,
        ST_SURR     = 3'd5,
        ST_BEYOND   = 3'd6
    } t_status;

    localparam logic [BYTE_W-1:0] LEAD_E0      = 8'hE0;
    localparam logic [BYTE_W-1:0] CONT_MIN_3B  = 8'hA0;
    localparam logic [BYTE_W-1:0] LEAD_MIN_2B  = 8'hC2;

    // Decode outcome for one byte
    typedef struct packed {
        logic              emit;
        logic [UNIT_W-1:0] code_unit;
        t_status           status;
        t_phase            next_phase;
        logic              load_lead;
        logic              load_first;
    } t_dec;

endpackage

>>> src/utf8_to_utf16_stream_decoder.sv
`timescale 1ns / 1ps

// UTF-8 to UTF-16 (basic multilingual plane) stream decoder. Feed one byte
// per beat on i_in_byte; a 0 byte ends the string and gives a result with
// status END. Every complete character gives one beat with its 16-bit code
// unit and status UNIT; bytes that start or continue a sequence give no beat.
// A malformed sequence gives one error beat (code unit 0), after which bytes
// are dropped up to and including the terminator; a 0 byte in place of a
// continuation reports MISSING and ends the string at once. The block takes
// one byte every cycle while o_stall is low: a byte sits in the input
// register while the decoder resolves it against the sequence state, and
// its result lands in the output register. i_stall on the output holds the
// result register and backs up into o_stall only when both registers are
// full and the waiting byte yields a result.
module utf8_to_utf16_stream_decoder (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [u8u16_pkg::BYTE_W-1:0]    i_in_byte,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [u8u16_pkg::UNIT_W-1:0]    o_code_unit,
    output logic [u8u16_pkg::STAT_W-1:0]    o_status
);
    import u8u16_pkg::*;

    // input register
    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    // sequence state
    t_phase            r_phase;
    logic [BYTE_W-1:0] r_lead;
    logic [BYTE_W-1:0] r_first;
    // result register
    logic              r_out_valid;
    logic [UNIT_W-1:0] r_code_unit;
    t_status           r_status;

    t_dec dec;
    logic out_free;
    logic s1_fire;
    logic in_take;

    u8u16_decode u_decode (
        .i_phase (r_phase),
        .i_lead  (r_lead),
        .i_first (r_first),
        .i_byte  (r_in_byte),
        .o_dec   (dec)
    );

    // The result slot frees up when empty or drained this cycle. A byte that
    // yields no result moves on regardless of the output side.
    assign out_free = !r_out_valid || !i_stall;
    assign s1_fire  = r_in_valid && (!dec.emit || out_free);
    assign o_stall  = r_in_valid && !s1_fire;
    assign in_take  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (s1_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_in_byte;
        end
    end

    // advance the sequence state once per consumed byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_lead  <= '0;
            r_first <= '0;
        end else if (s1_fire) begin
            r_phase <= dec.next_phase;
            if (dec.load_lead) begin
                r_lead <= r_in_byte;
            end
            if (dec.load_first) begin
                r_first <= r_in_byte;
            end
        end
    end

    // result register: load on a new result, clear when drained
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_fire && dec.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && dec.emit) begin
            r_code_unit <= dec.code_unit;
            r_status    <= dec.status;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_code_unit = r_code_unit;
    assign o_status    = r_status;

endmodule

>>> src/u8u16_decode.sv
`timescale 1ns / 1ps

module u8u16_decode (
    input  u8u16_pkg::t_phase            i_phase,
    input  logic [u8u16_pkg::BYTE_W-1:0] i_lead,
    input  logic [u8u16_pkg::BYTE_W-1:0] i_first,
    input  logic [u8u16_pkg::BYTE_W-1:0] i_byte,
    output u8u16_pkg::t_dec              o_dec
);
    import u8u16_pkg::*;

    logic              is_cont;
    logic              is_nul;
    t_phase            fail_phase;
    logic [UNIT_W-1:0] cu2;
    logic [UNIT_W-1:0] cu3;

    assign is_cont    = (i_byte[7:6] == 2'b10);
    assign is_nul     = (i_byte == '0);
    // a NUL ends the string now; anything else drops through the terminator
    assign fail_phase = is_nul ? PH_IDLE : PH_DROP;
    assign cu2        = {5'b0, i_lead[4:0], i_byte[5:0]};
    assign cu3        = {i_lead[3:0], i_first[5:0], i_byte[5:0]};

    always_comb begin
        o_dec            = '0;
        o_dec.status     = ST_UNIT;
        o_dec.next_phase = PH_IDLE;
        unique case (i_phase)
            PH_DROP: begin
                o_dec.next_phase = is_nul ? PH_IDLE : PH_DROP;
            end
            PH_TWO: begin
                o_dec.emit = 1'b1;
                if (!is_cont) begin
                    o_dec.status     = ST_MISSING;
                    o_dec.next_phase = fail_phase;
                end else if (i_lead < LEAD_MIN_2B) begin
                    o_dec.status     = ST_OVERLONG;
                    o_dec.next_phase = fail_phase;
                end else begin
                    o_dec.code_unit = cu2;
                end
            end
            PH_THREE1: begin
                if (!is_cont) begin
                    o_dec.emit       = 1'b1;
                    o_dec.status     = ST_MISSING;
                    o_dec.next_phase = fail_phase;
                end else begin
                    o_dec.load_first = 1'b1;
                    o_dec.next_phase = PH_THREE2;
                end
            end
            PH_THREE2: begin
                o_dec.emit = 1'b1;
                if (!is_cont) begin
                    o_dec.status     = ST_MISSING;
                    o_dec.next_phase = fail_phase;
                end else if (i_lead == LEAD_E0 && i_first < CONT_MIN_3B) begin
                    o_dec.status     = ST_OVERLONG;
                    o_dec.next_phase = fail_phase;
                end else if (cu3[15:11] == 5'b11011) begin
                    o_dec.status     = ST_SURR;
                    o_dec.next_phase = fail_phase;
                end else begin
                    o_dec.code_unit = cu3;
                end
            end
            default: begin
                // idle, and any code that is not a legal phase
                priority if (is_nul) begin
                    o_dec.emit   = 1'b1;
                    o_dec.status = ST_END;
                end else if (i_byte[7] == 1'b0) begin
                    o_dec.emit      = 1'b1;
                    o_dec.code_unit = {8'b0, i_byte};
                end else if (i_byte[7:6] == 2'b10) begin
                    o_dec.emit       = 1'b1;
                    o_dec.status     = ST_STRAY;
                    o_dec.next_phase = PH_DROP;
                end else if (i_byte[7:5] == 3'b110) begin
                    o_dec.load_lead  = 1'b1;
                    o_dec.next_phase = PH_TWO;
                end else if (i_byte[7:4] == 4'b1110) begin
                    o_dec.load_lead  = 1'b1;
                    o_dec.next_phase = PH_THREE1;
                end else begin
                    o_dec.emit       = 1'b1;
                    o_dec.status     = ST_BEYOND;
                    o_dec.next_phase = PH_DROP;
                end
            end
        endcase
    end

endmodule

>>> src/u8u16_checker.sv
`timescale 1ns / 1ps

module u8u16_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         o_stall,
    input logic [u8u16_pkg::BYTE_W-1:0] i_in_byte,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic [u8u16_pkg::UNIT_W-1:0] o_code_unit,
    input logic [u8u16_pkg::STAT_W-1:0] o_status
);
    import u8u16_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_code_unit) && $stable(o_status))
        else $error("result beat changed under stall");

    // end and error beats carry a zero code unit
    a_zero_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_UNIT |-> o_code_unit == '0)
        else $error("non-unit beat with nonzero code unit");

    // never deliver a surrogate as a code unit
    a_no_surr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_UNIT |-> o_code_unit[15:11] != 5'b11011)
        else $error("surrogate delivered as unit");

    // an empty pipe cannot stall the input
    a_stall_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled while output side free");

    // reset leaves no result pending
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind utf8_to_utf16_stream_decoder u8u16_checker u_u8u16_checker (.*);

>>> sim/utf16_unit_checker.sv
`timescale 1ns / 1ps

module utf16_unit_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic [u8u16_pkg::BYTE_W-1:0]    i_in_byte,
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic [u8u16_pkg::UNIT_W-1:0]    i_code_unit,
    input  logic [u8u16_pkg::STAT_W-1:0]    i_status,
    output int                              o_pending,
    output int                              o_fail_count
);

    import u8u16_pkg::*;

    localparam logic [BYTE_W-1:0] NUL       = 8'h00;
    localparam logic [BYTE_W-1:0] CONT_LO   = 8'h80;
    localparam logic [BYTE_W-1:0] LEAD_2B   = 8'hC0;
    localparam logic [BYTE_W-1:0] LEAD_4B   = 8'hF0;
    localparam logic [UNIT_W-1:0] SURR_LO   = 16'hD800;
    localparam logic [UNIT_W-1:0] SURR_END  = 16'hE000;

    typedef struct packed {
        logic [UNIT_W-1:0] unit;
        t_status           status;
    } t_unit_beat;

    t_unit_beat        units_due[$];
    t_phase            seq_phase;
    logic [BYTE_W-1:0] lead;
    logic [BYTE_W-1:0] first_cont;
    int                fails;

    function automatic bit is_cont(input logic [BYTE_W-1:0] b);
        return (b >= CONT_LO) && (b < LEAD_2B);
    endfunction

    function automatic t_unit_beat beat(input logic [UNIT_W-1:0] u, input t_status s);
        t_unit_beat r;
        r.unit   = u;
        r.status = s;
        return r;
    endfunction

    // An error ends the string at a NUL, otherwise drop through the terminator
    task automatic report_error(input logic [BYTE_W-1:0] b, input t_status s);
        seq_phase = (b == NUL) ? PH_IDLE : PH_DROP;
        units_due.push_back(beat('0, s));
    endtask

    task automatic decode_byte(input logic [BYTE_W-1:0] b);
        logic [UNIT_W-1:0] cu;
        case (seq_phase)
            PH_DROP: begin
                if (b == NUL) seq_phase = PH_IDLE;
            end
            PH_TWO: begin
                if (!is_cont(b)) begin
                    report_error(b, ST_MISSING);
                end else if (lead < LEAD_MIN_2B) begin
                    report_error(b, ST_OVERLONG);
                end else begin
                    seq_phase = PH_IDLE;
                    units_due.push_back(beat({5'b0, lead[4:0], b[5:0]}, ST_UNIT));
                end
            end
            PH_THREE1: begin
                if (!is_cont(b)) begin
                    report_error(b, ST_MISSING);
                end else begin
                    first_cont = b;
                    seq_phase  = PH_THREE2;
                end
            end
            PH_THREE2: begin
                cu = {lead[3:0], first_cont[5:0], b[5:0]};
                if (!is_cont(b)) begin
                    report_error(b, ST_MISSING);
                end else if (lead == LEAD_E0 && first_cont < CONT_MIN_3B) begin
                    report_error(b, ST_OVERLONG);
                end else if (cu >= SURR_LO && cu < SURR_END) begin
                    report_error(b, ST_SURR);
                end else begin
                    seq_phase = PH_IDLE;
                    units_due.push_back(beat(cu, ST_UNIT));
                end
            end
            default: begin
                seq_phase = PH_IDLE;
                if (b == NUL) begin
                    units_due.push_back(beat('0, ST_END));
                end else if (b < CONT_LO) begin
                    units_due.push_back(beat({8'b0, b}, ST_UNIT));
                end else if (b < LEAD_2B) begin
                    report_error(b, ST_STRAY);
                end else if (b < LEAD_E0) begin
                    lead      = b;
                    seq_phase = PH_TWO;
                end else if (b < LEAD_4B) begin
                    lead      = b;
                    seq_phase = PH_THREE1;
                end else begin
                    report_error(b, ST_BEYOND);
                end
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_unit_beat want;
        if (!i_rst_n) begin
            seq_phase  = PH_IDLE;
            lead       = '0;
            first_cont = '0;
            fails      = 0;
            units_due.delete();
        end else begin
            if (i_in_valid && !i_in_stall) decode_byte(i_in_byte);
            if (i_out_valid && !i_out_stall) begin
                if (units_due.size() == 0) begin
                    $display("%0t: unexpected beat: expected none, actual unit %h status %0d",
                             $time, i_code_unit, i_status);
                    fails++;
                end else begin
                    want = units_due.pop_front();
                    if (i_code_unit !== want.unit) begin
                        $display("%0t: code unit mismatch: expected %h, actual %h",
                                 $time, want.unit, i_code_unit);
                        fails++;
                    end
                    if (i_status !== want.status) begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, i_status);
                        fails++;
                    end
                end
            end
        end
        o_pending    <= units_due.size();
        o_fail_count <= fails;
    end

endmodule

>>> sim/tb_utf8_to_utf16_stream_decoder.sv
`timescale 1ns / 1ps

// Byte stream in, code units out. The top only drives bytes and the output
// stall; the checker beside the decoder predicts every beat and counts
// failures, which the top turns into the verdict.
module tb_utf8_to_utf16_stream_decoder;

    import u8u16_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int ITEMS_PER_PHASE = 250;

    localparam logic [BYTE_W-1:0] NUL = 8'h00;

    // Directed opening: boundaries of each length and every error kind
    localparam logic [BYTE_W-1:0] DIRECTED [33] = '{
        8'h00,                      // empty string, end only
        8'h7F,                      // largest single byte
        8'h80, 8'h00,               // stray continuation, then terminator dropped
        8'hC2, 8'h80,               // smallest 2-byte form
        8'hDF, 8'hBF,               // largest 2-byte form
        8'hC1, 8'hBF, 8'h00,        // overlong 2-byte form
        8'hC0, 8'h41, 8'h00,        // missing continuation wins over overlong
        8'hE0, 8'hA0, 8'h80,        // smallest 3-byte form
        8'hEF, 8'hBF, 8'hBF,        // largest code unit
        8'hE0, 8'h9F, 8'hBF, 8'h00, // overlong 3-byte form
        8'hED, 8'hA0, 8'h80, 8'h00, // surrogate
        8'hF0, 8'h00,               // lead beyond the basic plane
        8'hE2, 8'h80, 8'h00         // NUL inside a sequence ends the string
    };

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [BYTE_W-1:0] in_byte = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [UNIT_W-1:0] code_unit;
    logic [STAT_W-1:0] status;

    int pending;
    int fail_count;
    int cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int items_sent = 0;
    bit dropping = 1'b0;

    utf8_to_utf16_stream_decoder i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_valid     (in_valid),
        .o_stall     (in_stall),
        .i_in_byte   (in_byte),
        .o_valid     (out_valid),
        .i_stall     (out_stall),
        .o_code_unit (code_unit),
        .o_status    (status)
    );

    utf16_unit_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_byte    (in_byte),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_code_unit  (code_unit),
        .i_status     (status),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Give up on a hung run
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Receiver side: stall at the rate of the current phase
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Drive one beat: idle first at random, then hold the byte until accepted.
    // Bytes sent while the decoder drops the rest of a string do not count.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        do @(posedge clk); while (in_stall);
        if (!dropping) items_sent++;
    endtask

    function automatic logic [BYTE_W-1:0] rand_cont();
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // Any byte that cannot continue a sequence, NUL included
    function automatic logic [BYTE_W-1:0] rand_non_cont();
        if ($urandom_range(0, 1)) return 8'($urandom_range(0, 127));
        return 8'($urandom_range(192, 255));
    endfunction

    // Mostly well-formed strings with random content; a few broken sequences
    task automatic send_string();
        int                n_chars;
        int                kind;
        int                i;
        logic [BYTE_W-1:0] lead;
        n_chars  = $urandom_range(1, 8);
        dropping = 1'b0;
        for (i = 0; i < n_chars && !dropping; i++) begin
            kind = $urandom_range(0, 19);
            if (kind <= 5) begin
                send_byte(8'($urandom_range(1, 127)));
            end else if (kind <= 10) begin
                send_byte(8'($urandom_range(8'hC2, 8'hDF)));
                send_byte(rand_cont());
            end else if (kind <= 15) begin
                lead = 8'($urandom_range(8'hE0, 8'hEF));
                send_byte(lead);
                if (lead == 8'hE0) begin
                    send_byte(8'($urandom_range(8'hA0, 8'hBF)));
                end else if (lead == 8'hED) begin
                    send_byte(8'($urandom_range(8'h80, 8'h9F)));
                end else begin
                    send_byte(rand_cont());
                end
                send_byte(rand_cont());
            end else if (kind == 16) begin
                // raw noise: whatever it turns out to be
                send_byte(8'($urandom_range(0, 255)));
            end else if (kind == 17) begin
                // truncated sequence at either continuation slot
                lead = 8'($urandom_range(8'hC0, 8'hEF));
                send_byte(lead);
                if (lead >= 8'hE0 && $urandom_range(0, 1)) send_byte(rand_cont());
                send_byte(rand_non_cont());
                dropping = 1'b1;
            end else if (kind == 18) begin
                case ($urandom_range(0, 2))
                    0: begin
                        send_byte(8'($urandom_range(8'hC0, 8'hC1)));
                    end
                    1: begin
                        send_byte(8'hE0);
                        send_byte(8'($urandom_range(8'h80, 8'h9F)));
                    end
                    default: begin
                        send_byte(8'hED);
                        send_byte(8'($urandom_range(8'hA0, 8'hBF)));
                    end
                endcase
                send_byte(rand_cont());
                dropping = 1'b1;
            end else begin
                send_byte(8'($urandom_range(8'hF0, 8'hFF)));
                dropping = 1'b1;
            end
        end
        // junk after an error must be swallowed up to the terminator
        if (dropping) begin
            repeat ($urandom_range(0, 3)) send_byte(8'($urandom_range(1, 255)));
        end
        send_byte(NUL);
        dropping = 1'b0;
    endtask

    initial begin
        int ph;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[k]) send_byte(DIRECTED[k]);

        // Phases: free flow, slow sender, slow receiver, both
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            items_sent = 0;
            while (items_sent < ITEMS_PER_PHASE) send_string();
        end

        in_valid <= 1'b0;
        recv_stall_pct = 24;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
